>>> rtl/pdd_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the scale code table of the polyline delta decoder
// no dependencies
package pdd_pkg;

   localparam int BYTE_W       = 8;
   localparam int RAW_W        = 24;
   localparam int SCALE_W      = 14;
   localparam int OUT_W        = 48;
   localparam int STATUS_W     = 2;
   localparam int CNT_W        = 4;
   localparam int NIB_W        = 4;
   localparam int PROD_W       = RAW_W + SCALE_W + 1;
   localparam int DPROD_W      = NIB_W + SCALE_W + 1;
   localparam int POS_WIDTH_DEF = 48;

   // frame positions
   localparam logic [CNT_W-1:0] IDX_SCALE   = 4'd1;
   localparam logic [CNT_W-1:0] IDX_LAT_LO  = 4'd2;
   localparam logic [CNT_W-1:0] IDX_LAT_HI  = 4'd4;
   localparam logic [CNT_W-1:0] IDX_LON_LO  = 4'd5;
   localparam logic [CNT_W-1:0] IDX_LON_HI  = 4'd7;
   localparam logic [CNT_W-1:0] IDX_LAT_MUL = 4'd5;
   localparam logic [CNT_W-1:0] IDX_FIRST   = 4'd7;
   localparam logic [CNT_W-1:0] HDR_LEN     = 4'd8;

   // scale code ranges
   localparam logic [BYTE_W-1:0] CODE_DIRECT_MIN = 8'd1;
   localparam logic [BYTE_W-1:0] CODE_DIRECT_END = 8'd200;
   localparam logic [BYTE_W-1:0] CODE_TABLE_MIN  = 8'd227;
   localparam logic [BYTE_W-1:0] CODE_TABLE_MAX  = 8'd239;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SHORT     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_SCALE = 2'd2;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              frame_start;
      logic              frame_end;
   } item_type;

   typedef struct packed {
      logic [OUT_W-1:0]    lat_pos;
      logic [OUT_W-1:0]    lon_pos;
      logic [STATUS_W-1:0] status;
      logic                last_of_frame;
   } result_type;

   typedef struct packed {
      logic               valid;
      logic [SCALE_W-1:0] value;
   } scale_type;

   function automatic scale_type decode_scale(input logic [BYTE_W-1:0] code);
      scale_type s;
      s.valid = 1'b1;
      s.value = '0;
      priority if (code >= CODE_DIRECT_MIN && code < CODE_DIRECT_END) begin
         s.value = SCALE_W'(code);
      end else if (code >= CODE_TABLE_MIN && code <= CODE_TABLE_MAX) begin
         unique case (code)
            8'd227:  s.value = 14'd1;
            8'd228:  s.value = 14'd2;
            8'd229:  s.value = 14'd5;
            8'd230:  s.value = 14'd10;
            8'd231:  s.value = 14'd20;
            8'd232:  s.value = 14'd50;
            8'd233:  s.value = 14'd100;
            8'd234:  s.value = 14'd200;
            8'd235:  s.value = 14'd500;
            8'd236:  s.value = 14'd1000;
            8'd237:  s.value = 14'd2000;
            8'd238:  s.value = 14'd5000;
            8'd239:  s.value = 14'd10000;
            default: s.value = '0;
         endcase
      end else begin
         s.valid = 1'b0;
      end
      return s;
   endfunction

endpackage

>>> rtl/pdd_in_stage.sv
`timescale 1ns / 1ps
// input register of the polyline delta decoder: holds one accepted byte
// depends on pdd_pkg
module pdd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  pdd_pkg::item_type req_item,
   input  logic              take,
   output logic              item_valid,
   output pdd_pkg::item_type item
);

   logic              valid_ff, valid_in;
   pdd_pkg::item_type item_ff;

   // a new word may enter in the same cycle the held one is taken
   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> rtl/pdd_core.sv
`timescale 1ns / 1ps
// frame parser, scaler and running position accumulators
// depends on pdd_pkg
module pdd_core #(
   parameter int POS_WIDTH = pdd_pkg::POS_WIDTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  pdd_pkg::item_type   item,
   input  logic                out_free,
   output logic                take,
   output logic                res_valid,
   output pdd_pkg::result_type res
);

   logic [pdd_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [pdd_pkg::SCALE_W-1:0] scale_ff, scale_in;
   logic                        scale_valid_ff, scale_valid_in;
   logic [pdd_pkg::RAW_W-1:0]   raw_lat_ff, raw_lat_in;
   logic [pdd_pkg::RAW_W-1:0]   raw_lon_ff, raw_lon_in;
   logic [POS_WIDTH-1:0]        acc_lat_ff, acc_lat_in;
   logic [POS_WIDTH-1:0]        acc_lon_ff, acc_lon_in;

   logic [pdd_pkg::CNT_W-1:0]         idx;
   pdd_pkg::scale_type                scale_dec;
   logic [pdd_pkg::RAW_W-1:0]         mul_a;
   logic signed [pdd_pkg::PROD_W-1:0] prod;
   logic signed [pdd_pkg::DPROD_W-1:0] dlat_prod, dlon_prod;
   logic [POS_WIDTH-1:0]              prod_ext, lat_sum, lon_sum;
   logic [POS_WIDTH+pdd_pkg::OUT_W-1:0] lat_wide, lon_wide;
   logic [POS_WIDTH-1:0]              lat_pick, lon_pick;

   assign idx       = item.frame_start ? '0 : count_ff;
   assign scale_dec = pdd_pkg::decode_scale(item.data_byte);

   // one multiplier: latitude header on the first longitude byte, longitude on the last
   assign mul_a = (idx == pdd_pkg::IDX_FIRST) ? {raw_lon_ff[15:0], item.data_byte}
                                              : raw_lat_ff;
   assign prod     = $signed(mul_a) * $signed({1'b0, scale_ff});
   assign prod_ext = POS_WIDTH'(prod);

   assign dlat_prod = $signed(item.data_byte[3:0]) * $signed({1'b0, scale_ff});
   assign dlon_prod = $signed(item.data_byte[7:4]) * $signed({1'b0, scale_ff});
   assign lat_sum   = acc_lat_ff + POS_WIDTH'(dlat_prod);
   assign lon_sum   = acc_lon_ff + POS_WIDTH'(dlon_prod);

   always_comb begin
      scale_in       = scale_ff;
      scale_valid_in = scale_valid_ff;
      raw_lat_in     = raw_lat_ff;
      raw_lon_in     = raw_lon_ff;
      acc_lat_in     = acc_lat_ff;
      acc_lon_in     = acc_lon_ff;
      res_valid      = 1'b0;
      lat_pick       = '0;
      lon_pick       = '0;
      res.status        = pdd_pkg::ST_OK;
      res.last_of_frame = item.frame_end;

      if (idx == pdd_pkg::IDX_SCALE) begin
         scale_in       = scale_dec.value;
         scale_valid_in = scale_dec.valid;
      end
      if (idx >= pdd_pkg::IDX_LAT_LO && idx <= pdd_pkg::IDX_LAT_HI) begin
         raw_lat_in = {raw_lat_ff[15:0], item.data_byte};
      end
      if (idx >= pdd_pkg::IDX_LON_LO && idx <= pdd_pkg::IDX_LON_HI) begin
         raw_lon_in = {raw_lon_ff[15:0], item.data_byte};
      end
      // the header latitude is complete once its last byte is in
      if (idx == pdd_pkg::IDX_LAT_MUL) begin
         acc_lat_in = prod_ext;
      end

      priority if (idx < pdd_pkg::IDX_FIRST) begin
         res_valid  = item.frame_end;
         res.status = pdd_pkg::ST_SHORT;
      end else if (!scale_valid_ff) begin
         res_valid  = item.frame_end;
         res.status = pdd_pkg::ST_BAD_SCALE;
      end else if (idx == pdd_pkg::IDX_FIRST) begin
         acc_lon_in = prod_ext;
         res_valid  = 1'b1;
         lat_pick   = acc_lat_ff;
         lon_pick   = prod_ext;
      end else begin
         acc_lat_in = lat_sum;
         acc_lon_in = lon_sum;
         res_valid  = 1'b1;
         lat_pick   = lat_sum;
         lon_pick   = lon_sum;
      end

      if (item.frame_end) begin
         count_in = '0;
      end else if (idx < pdd_pkg::HDR_LEN) begin
         count_in = idx + 1'b1;
      end else begin
         count_in = idx;
      end

      // positions leave zero-extended or truncated to the output width
      lat_wide    = {{pdd_pkg::OUT_W{1'b0}}, lat_pick};
      lon_wide    = {{pdd_pkg::OUT_W{1'b0}}, lon_pick};
      res.lat_pos = lat_wide[pdd_pkg::OUT_W-1:0];
      res.lon_pos = lon_wide[pdd_pkg::OUT_W-1:0];
   end

   assign take = item_valid && (out_free || !res_valid);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         scale_ff       <= '0;
         scale_valid_ff <= 1'b0;
         raw_lat_ff     <= '0;
         raw_lon_ff     <= '0;
         acc_lat_ff     <= '0;
         acc_lon_ff     <= '0;
      end else if (take) begin
         count_ff       <= count_in;
         scale_ff       <= scale_in;
         scale_valid_ff <= scale_valid_in;
         raw_lat_ff     <= raw_lat_in;
         raw_lon_ff     <= raw_lon_in;
         acc_lat_ff     <= acc_lat_in;
         acc_lon_ff     <= acc_lon_in;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pdd_pkg::HDR_LEN)
      else $error("frame position counter beyond header length");

   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      take && item.frame_end |=> count_ff == '0)
      else $error("frame end did not restart the frame position");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      take && res_valid && res.status != pdd_pkg::ST_OK |->
         res.last_of_frame && res.lat_pos == '0 && res.lon_pos == '0)
      else $error("status word with nonzero position or not at frame end");

   a_point_scaled: assert property (@(posedge clock) disable iff (reset)
      take && res_valid && res.status == pdd_pkg::ST_OK |->
         scale_valid_ff && idx >= pdd_pkg::IDX_FIRST)
      else $error("point emitted without a valid scale or complete header");

   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      item_valid && !out_free && res_valid |-> !take)
      else $error("result produced while output register is full");

endmodule

>>> rtl/pdd_out_stage.sv
`timescale 1ns / 1ps
// result register of the polyline delta decoder
// depends on pdd_pkg
module pdd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  pdd_pkg::result_type res,
   output logic                out_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output pdd_pkg::result_type rsp_res
);

   logic                valid_ff, valid_in;
   pdd_pkg::result_type res_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_res    = res_ff;

endmodule

>>> rtl/polyline_delta_decoder_top.sv
`timescale 1ns / 1ps
// top level of the polyline delta decoder
// depends on pdd_pkg, pdd_in_stage, pdd_core, pdd_out_stage
//
// Decodes a framed polyline byte stream, one byte per cycle in steady state: a byte
// accepted on req_ is registered in the input stage, decoded against the frame state
// and, if it gives a result, registered in the output stage and driven on rsp_, one
// byte per cycle as long as rsp_tready is high. The rate is set by a single 24x15
// signed multiplier shared between the latitude header (scaled on frame byte 5) and
// the longitude header (scaled on frame byte 7), plus a narrow delta multiply and a
// POS_WIDTH-bit add per axis for every later byte. Frame bytes 0 to 6 give no result,
// byte 7 gives the first point; a frame ending before 8 bytes gives one short-frame
// status word and a frame with an invalid scale code gives one bad-scale status word
// at its end. Positions are in units of 1e-4 degree and wrap at POS_WIDTH bits.
module polyline_delta_decoder_top #(
   parameter int POS_WIDTH = pdd_pkg::POS_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // frame_start
   input  logic         req_tlast,   // frame_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // lat_pos [47:0], lon_pos [95:48]
   output logic [1:0]   rsp_tuser,   // status
   output logic         rsp_tlast    // last_of_frame
);

   pdd_pkg::item_type   req_item, item;
   pdd_pkg::result_type res, rsp_res;
   logic                item_valid, take, res_valid, out_free;

   assign req_item.data_byte   = req_tdata;
   assign req_item.frame_start = req_tuser;
   assign req_item.frame_end   = req_tlast;

   pdd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   pdd_core #(
      .POS_WIDTH (POS_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .res_valid  (res_valid),
      .res        (res)
   );

   pdd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (take && res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_res    (rsp_res)
   );

   assign rsp_tdata = {rsp_res.lon_pos, rsp_res.lat_pos};
   assign rsp_tuser = rsp_res.status;
   assign rsp_tlast = rsp_res.last_of_frame;

endmodule
